### design/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// types, constants and codes shared by the timed motor move block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int ANGLE_WIDTH = 16;

  localparam int DUTY_W   = 8;
  localparam int RPM_W    = 10;
  localparam int GEAR_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;
  localparam int DSUM_W   = DUTY_W + 2;
  localparam int RG_W     = RPM_W + GEAR_W;
  localparam int DIV_W    = RG_W + DSUM_W;

  localparam int SCALE_W  = 20;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(680000);

  localparam int NUM_W    = ANGLE_WIDTH + SCALE_W;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int EXT_W    = ((NUM_W > TIME_WIDTH) ? NUM_W : TIME_WIDTH) + 1;

  localparam int S_DATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;
  localparam int RES_W    = 2 * DUTY_W + 2 + 1;
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [CFG_AW-1:0] CFG_START_DUTY  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_CRUISE_DUTY = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_STOP_DUTY   = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_MOTOR_RPM   = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] CFG_GEAR_RATIO  = CFG_AW'(4);

  localparam logic FUNC_MOVE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL2,
    ST_CHECK,
    ST_DIV,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic cap;
    logic do_tick;
    logic set_ignored;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_step;
    logic load_move;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic busy;
    logic mag_zero;
    logic div_zero;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/tpm_ctrl.sv
// ----------------------------------------------------------------------------
// tpm_ctrl
// sequencer for one item: decode, multiply, divide, load, emit result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_ctrl
  import tpm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.cap    = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_tick) begin
          cmd.do_tick = 1'b1;
          state_next  = ST_EMIT;
        end else if (stat.busy) begin
          cmd.set_ignored = 1'b1;
          state_next      = ST_EMIT;
        end else if (stat.mag_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.div_zero) begin
          cmd.set_ignored = 1'b1;
          state_next      = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_move = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/tpm_dp.sv
// ----------------------------------------------------------------------------
// tpm_dp
// registers, phase timer, multipliers, restoring divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_dp
  import tpm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic [S_DATA_W-1:0]    s_tdata,
  input  wire logic [0:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_DATA_W-1:0]         m_tdata,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat
);

  logic [DUTY_W-1:0]      start_duty, cruise_duty, stop_duty;
  logic [RPM_W-1:0]       motor_rpm;
  logic [GEAR_W-1:0]      gear_ratio_q8;

  phase_t                 phase_now;
  logic                   dir_forward;
  logic [TIME_WIDTH-1:0]  ticks_left;
  logic [TIME_WIDTH-1:0]  phase_length;

  logic                   func_reg;
  logic [ANGLE_WIDTH-1:0] angle_reg;
  logic                   ignored;

  logic [NUM_W-1:0]       num_reg;
  logic [RG_W-1:0]        rg_reg;
  logic [DIV_W-1:0]       divisor;
  logic [DIV_W-1:0]       rem;
  logic [NUM_W-1:0]       quo;
  logic [CNT_W-1:0]       cnt;

  logic [ANGLE_WIDTH-1:0] mag;
  logic [DSUM_W-1:0]      dsum;
  logic [DIV_W:0]         rem_sh;
  logic                   qbit;
  logic [EXT_W-1:0]       quo_ext;
  logic [TIME_WIDTH-1:0]  len;
  logic [TIME_WIDTH-1:0]  tl_dec;
  logic [DUTY_W-1:0]      duty;
  logic [DUTY_W-1:0]      in1_duty, in2_duty;

  assign mag  = angle_reg[ANGLE_WIDTH-1] ? (~angle_reg + 1'b1) : angle_reg;
  assign dsum = DSUM_W'(start_duty) + DSUM_W'(cruise_duty) + DSUM_W'(stop_duty);

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, divisor});

  assign quo_ext = EXT_W'(quo);
  assign len     = (quo_ext > EXT_W'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                                                            : quo_ext[TIME_WIDTH-1:0];
  assign tl_dec  = (ticks_left != '0) ? (ticks_left - 1'b1) : '0;

  always_comb begin
    unique case (phase_now)
      PH_ACCEL:  duty = start_duty;
      PH_CRUISE: duty = cruise_duty;
      PH_DECEL:  duty = stop_duty;
      default:   duty = '0;
    endcase
  end

  assign in1_duty = dir_forward ? duty : '0;
  assign in2_duty = dir_forward ? '0 : duty;

  assign stat.is_tick  = (func_reg == FUNC_TICK);
  assign stat.busy     = (phase_now != PH_IDLE);
  assign stat.mag_zero = (angle_reg == '0);
  assign stat.div_zero = (divisor == '0);
  assign stat.div_last = (cnt == CNT_W'(NUM_W - 1));
  assign stat.out_free = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_duty    <= DUTY_W'(100);
      cruise_duty   <= DUTY_W'(200);
      stop_duty     <= DUTY_W'(100);
      motor_rpm     <= RPM_W'(60);
      gear_ratio_q8 <= GEAR_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_DUTY:  start_duty    <= cfg_wdata[DUTY_W-1:0];
        CFG_CRUISE_DUTY: cruise_duty   <= cfg_wdata[DUTY_W-1:0];
        CFG_STOP_DUTY:   stop_duty     <= cfg_wdata[DUTY_W-1:0];
        CFG_MOTOR_RPM:   motor_rpm     <= cfg_wdata[RPM_W-1:0];
        CFG_GEAR_RATIO:  gear_ratio_q8 <= cfg_wdata[GEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_now    <= PH_IDLE;
      dir_forward  <= 1'b0;
      ticks_left   <= '0;
      phase_length <= '0;
    end else if (cmd.do_tick && phase_now != PH_IDLE) begin
      if (tl_dec == '0) begin
        if (phase_now == PH_DECEL) begin
          phase_now  <= PH_IDLE;
          ticks_left <= '0;
        end else begin
          phase_now  <= phase_t'(phase_now + 2'd1);
          ticks_left <= phase_length;
        end
      end else begin
        ticks_left <= tl_dec;
      end
    end else if (cmd.load_move && len != '0) begin
      phase_now    <= PH_ACCEL;
      dir_forward  <= ~angle_reg[ANGLE_WIDTH-1];
      phase_length <= len;
      ticks_left   <= len;
    end
  end

  // captured item and working registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_reg  <= s_tuser[0];
      angle_reg <= s_tdata[ANGLE_WIDTH-1:0];
    end
    if (cmd.cap) begin
      ignored <= 1'b0;
    end else if (cmd.set_ignored) begin
      ignored <= 1'b1;
    end
    if (cmd.mul1) begin
      num_reg <= NUM_W'(mag) * NUM_W'(SCALE);
      rg_reg  <= RG_W'(motor_rpm) * RG_W'(gear_ratio_q8);
    end
    if (cmd.mul2) begin
      divisor <= DIV_W'(rg_reg) * DIV_W'(dsum);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= num_reg;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
      quo <= {quo[NUM_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= M_DATA_W'({ignored, phase_now, in2_duty, in1_duty});
    end
  end

endmodule

`default_nettype wire

### design/three_phase_timed_motor_move_top.sv
// ----------------------------------------------------------------------------
// three_phase_timed_motor_move_top
// timed accelerate / cruise / decelerate move of one h-bridge motor
// ----------------------------------------------------------------------------
// sequence: a tick, a move while busy or a zero angle goes from decode to the
//   output register, a zero divisor after the two multiplies; any other move
//   also runs the 36-step divider and loads the move before its result beat
// throughput: one item at a time; the next beat is taken once the result
//   sits in the output register, which holds it until taken
// reset: synchronous, clears the move state, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module three_phase_timed_motor_move_top
  import tpm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_AW-1:0]   cfg_addr,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // angle_sixteenths
  input  wire logic [0:0]          s_tuser,   // func
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // in1_duty, in2_duty, move_phase, cmd_ignored
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
